[rtl/chunked_frame_reassembly_tracker_macros.svh]
// assertion macros used by the checker file
`ifndef CHUNKED_FRAME_REASSEMBLY_TRACKER_MACROS_SVH
`define CHUNKED_FRAME_REASSEMBLY_TRACKER_MACROS_SVH

// same-cycle implication, quiet during reset
`define CFRT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("cfrt assertion failed");

// next-cycle implication, quiet during reset
`define CFRT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("cfrt assertion failed");

// next-cycle implication that also covers reset itself
`define CFRT_ASSERT_NEXT_ALWAYS(label, ante, cons) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("cfrt assertion failed");

`endif

[rtl/cfrt_pkg.sv]
// shared types, codes and constants of the frame reassembly tracker
package cfrt_pkg;

    localparam int StreamsDef   = 16;
    localparam int MaxChunksDef = 64;
    localparam int MapW         = 64;
    localparam int IdxW         = 6;

    localparam logic [15:0] MaxChunkBytesRst = 16'd60000;
    localparam logic [21:0] MaxFrameBytesRst = 22'd2097152;

    // input kind codes
    localparam logic [1:0] KIND_SINGLE = 2'd0;
    localparam logic [1:0] KIND_CHUNK  = 2'd1;

    // configuration register indexes
    localparam logic CFG_MAX_CHUNK = 1'b0;
    localparam logic CFG_MAX_FRAME = 1'b1;

    typedef enum logic [2:0] {
        ST_STORED     = 3'd0,
        ST_COMPLETE   = 3'd1,
        ST_MALFORMED  = 3'd2,
        ST_BAD_SIZE   = 3'd3,
        ST_BAD_META   = 3'd4,
        ST_TRUNCATED  = 3'd5,
        ST_INCOMPLETE = 3'd6,
        ST_UNKNOWN    = 3'd7
    } t_status;

    typedef enum logic [1:0] {
        OP_DONE   = 2'd0,
        OP_SINGLE = 2'd1,
        OP_CHUNK  = 2'd2
    } t_op;

    // classified item passed from front to back
    typedef struct packed {
        t_op         op;
        t_status     status;
        logic [15:0] sid;
        logic [15:0] width;
        logic [15:0] height;
        logic [31:0] seq;
        logic [21:0] total;
        logic [IdxW-1:0] idx;
        logic [6:0]  cnt;
        logic [15:0] size;
    } t_job;

    // per-stream record
    typedef struct packed {
        logic [31:0]     last_seq;
        logic [31:0]     rcv;
        logic [31:0]     drop;
        logic [31:0]     pseq;
        logic [21:0]     ptot;
        logic [6:0]      pparts;
        logic [31:0]     geom;
        logic [MapW-1:0] map;
        logic [6:0]      seen_cnt;
        logic [21:0]     sum;
    } t_rec;

endpackage

[rtl/cfrt_front.sv]
// front end: checks one header and turns it into a job for the back end
module cfrt_front
    import cfrt_pkg::*;
#(
    parameter int STREAMS    = StreamsDef,
    parameter int MAX_CHUNKS = MaxChunksDef
) (
    input  logic [1:0]  i_kind,
    input  logic [15:0] i_stream_id,
    input  logic [15:0] i_frame_width,
    input  logic [15:0] i_frame_height,
    input  logic [31:0] i_frame_sequence,
    input  logic [31:0] i_total_bytes,
    input  logic [15:0] i_part_index,
    input  logic [15:0] i_part_count,
    input  logic [31:0] i_part_bytes,
    input  logic [15:0] i_bytes_present,
    input  logic [15:0] i_max_chunk,
    input  logic [21:0] i_max_frame,
    output t_job        o_job
);

    logic size_bad;
    logic meta_bad;
    logic trunc;
    logic unknown;

    // limit checks
    assign size_bad = (i_part_bytes == 32'd0) || (i_part_bytes > {16'd0, i_max_chunk});
    assign meta_bad = (i_total_bytes == 32'd0) || (i_total_bytes > {10'd0, i_max_frame})
                   || (i_part_count == 16'd0) || (i_part_count > 16'(MAX_CHUNKS))
                   || (i_part_index >= i_part_count) || size_bad;
    assign trunc    = {16'd0, i_bytes_present} < i_part_bytes;
    assign unknown  = i_stream_id >= 16'(STREAMS);

    // classification in check order
    always_comb begin
        o_job        = '0;
        o_job.op     = OP_DONE;
        o_job.status = ST_MALFORMED;
        o_job.sid    = i_stream_id;
        o_job.width  = i_frame_width;
        o_job.height = i_frame_height;
        o_job.seq    = i_frame_sequence;
        o_job.total  = i_total_bytes[21:0];
        o_job.idx    = i_part_index[IdxW-1:0];
        o_job.cnt    = i_part_count[6:0];
        o_job.size   = i_part_bytes[15:0];
        if (i_kind == KIND_SINGLE) begin
            priority if (size_bad) o_job.status = ST_BAD_SIZE;
            else if (trunc)        o_job.status = ST_TRUNCATED;
            else if (unknown)      o_job.status = ST_UNKNOWN;
            else                   o_job.op     = OP_SINGLE;
        end else if (i_kind == KIND_CHUNK) begin
            priority if (meta_bad) o_job.status = ST_BAD_META;
            else if (trunc)        o_job.status = ST_TRUNCATED;
            else if (unknown)      o_job.status = ST_UNKNOWN;
            else                   o_job.op     = OP_CHUNK;
        end else begin
            o_job.sid = 16'd0;
        end
    end

endmodule

[rtl/cfrt_queue.sv]
// two-entry job queue between front and back
module cfrt_queue
    import cfrt_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_job o_job
);

    t_job       r_mem [2];
    logic       r_wp, n_wp;
    logic       r_rp, n_rp;
    logic [1:0] r_cnt, n_cnt;

    assign o_full  = r_cnt == 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_job   = r_mem[r_rp];

    // pointer and fill update
    always_comb begin
        n_wp  = r_wp ^ i_push;
        n_rp  = r_rp ^ i_pop;
        n_cnt = r_cnt + {1'b0, i_push} - {1'b0, i_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_job;
    end

endmodule

[rtl/cfrt_back.sv]
// back end: per-stream read-modify-write and the result register
module cfrt_back
    import cfrt_pkg::*;
#(
    parameter int STREAMS    = StreamsDef,
    parameter int MAX_CHUNKS = MaxChunksDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_valid,
    input  t_job        i_q_job,
    output logic        o_q_pop,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_status,
    output logic [15:0] o_out_stream,
    output logic [15:0] o_out_width,
    output logic [15:0] o_out_height,
    output logic [31:0] o_out_sequence,
    output logic [31:0] o_frames_received,
    output logic [31:0] o_frames_dropped
);

    localparam int SidW  = (STREAMS > 1) ? $clog2(STREAMS) : 1;
    localparam int Slots = STREAMS * MAX_CHUNKS;
    localparam int SlotW = (Slots > 1) ? $clog2(Slots) : 1;
    localparam int ChW   = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state       r_state, n_state;
    t_rec         r_rec_mem [STREAMS];
    logic [STREAMS-1:0] r_rec_vld;
    logic [15:0]  r_size_mem [Slots];
    t_rec         r_rec_q;
    logic         r_rec_q_vld;
    logic [15:0]  r_old_size;
    t_job         r_job;
    logic         r_out_valid;
    t_status      r_status;
    logic [15:0]  r_stream, r_width, r_height;
    logic [31:0]  r_seq, r_rcv, r_drop;

    logic         out_free;
    logic         issue;
    logic         finish;
    logic [SlotW-1:0] head_slot;
    logic [SlotW-1:0] exec_slot;
    t_rec         rec;
    t_rec         nrec;
    t_status      x_status;
    logic [31:0]  x_geom;
    logic [MapW-1:0] bit_mask;

    function automatic logic [SlotW-1:0] slot_of(t_job j);
        slot_of = SlotW'(j.sid[SidW-1:0]) * SlotW'(MAX_CHUNKS) + SlotW'(j.idx[ChW-1:0]);
    endfunction

    function automatic t_rec clear_pending(t_rec r);
        t_rec c;
        c          = r;
        c.pseq     = '0;
        c.ptot     = '0;
        c.pparts   = '0;
        c.geom     = '0;
        c.map      = '0;
        c.seen_cnt = '0;
        c.sum      = '0;
        clear_pending = c;
    endfunction

    function automatic t_rec complete(t_rec r, logic [31:0] seq);
        t_rec c;
        c = r;
        if (r.last_seq != 32'd0 && seq > 32'(r.last_seq + 32'd1))
            c.drop = 32'(r.drop + 32'(seq - r.last_seq - 32'd1));
        c.last_seq = seq;
        c.rcv      = 32'(r.rcv + 32'd1);
        complete   = clear_pending(c);
    endfunction

    assign out_free  = !r_out_valid || !i_out_stall;
    assign o_q_pop   = (r_state == S_IDLE) && i_q_valid && out_free;
    assign issue     = o_q_pop && (i_q_job.op != OP_DONE);
    assign finish    = r_state == S_EXEC;
    assign head_slot = slot_of(i_q_job);
    assign exec_slot = slot_of(r_job);
    assign rec       = r_rec_q_vld ? r_rec_q : '0;
    assign bit_mask  = MapW'(1) << r_job.idx;

    // record update for the job in flight
    always_comb begin
        nrec     = rec;
        x_status = ST_COMPLETE;
        x_geom   = {r_job.width, r_job.height};
        if (r_job.op == OP_CHUNK) begin
            if (rec.pseq != r_job.seq || rec.ptot != r_job.total || rec.pparts != r_job.cnt) begin
                nrec        = clear_pending(rec);
                nrec.pseq   = r_job.seq;
                nrec.ptot   = r_job.total;
                nrec.pparts = r_job.cnt;
                nrec.geom   = {r_job.width, r_job.height};
            end
            // replaced chunk takes its old size back out of the sum
            if ((nrec.map & bit_mask) != '0) begin
                nrec.sum = 22'(nrec.sum - {6'd0, r_old_size});
            end else begin
                nrec.map      = nrec.map | bit_mask;
                nrec.seen_cnt = 7'(nrec.seen_cnt + 7'd1);
            end
            nrec.sum = 22'(nrec.sum + {6'd0, r_job.size});
            x_geom   = nrec.geom;
            priority if (nrec.seen_cnt < nrec.pparts) begin
                x_status = ST_STORED;
            end else if (nrec.sum != nrec.ptot) begin
                x_status = ST_INCOMPLETE;
                nrec     = clear_pending(nrec);
            end else begin
                nrec = complete(nrec, r_job.seq);
            end
        end else begin
            nrec = complete(rec, r_job.seq);
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (issue) n_state = S_EXEC;
            S_EXEC:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rec_vld   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (finish) r_rec_vld[r_job.sid[SidW-1:0]] <= 1'b1;
            if (finish || (o_q_pop && !issue)) r_out_valid <= 1'b1;
            else if (!i_out_stall)             r_out_valid <= 1'b0;
        end
    end

    // memory reads and writes
    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_rec_q     <= r_rec_mem[i_q_job.sid[SidW-1:0]];
            r_rec_q_vld <= r_rec_vld[i_q_job.sid[SidW-1:0]];
            r_old_size  <= r_size_mem[head_slot];
            r_job       <= i_q_job;
        end
        if (finish) begin
            r_rec_mem[r_job.sid[SidW-1:0]] <= nrec;
            if (r_job.op == OP_CHUNK) r_size_mem[exec_slot] <= r_job.size;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (o_q_pop && !issue) begin
            r_status <= i_q_job.status;
            r_stream <= i_q_job.sid;
            r_width  <= '0;
            r_height <= '0;
            r_seq    <= '0;
            r_rcv    <= '0;
            r_drop   <= '0;
        end else if (finish) begin
            r_status <= x_status;
            r_stream <= r_job.sid;
            r_rcv    <= nrec.rcv;
            r_drop   <= nrec.drop;
            if (x_status == ST_COMPLETE) begin
                r_width  <= x_geom[31:16];
                r_height <= x_geom[15:0];
                r_seq    <= r_job.seq;
            end else begin
                r_width  <= '0;
                r_height <= '0;
                r_seq    <= '0;
            end
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_status          = r_status;
    assign o_out_stream      = r_stream;
    assign o_out_width       = r_width;
    assign o_out_height      = r_height;
    assign o_out_sequence    = r_seq;
    assign o_frames_received = r_rcv;
    assign o_frames_dropped  = r_drop;

endmodule

[rtl/chunked_frame_reassembly_tracker.sv]
// top level of the chunked frame reassembly tracker
// Usage:
//   Input channel: one parsed datagram header per item (i_in_valid/o_in_stall).
//   Output channel: exactly one result item per input item (o_out_valid/i_out_stall),
//   in input order.
//   Configuration: i_cfg_we with i_cfg_idx (0 max chunk bytes, 1 max frame bytes)
//   and i_cfg_data, written only while the block is idle.
// Path: a header that fails a check goes from the queue straight into the result
//   register; a header that touches stream state first has its record read and updated.
// Back end: a stream header occupies it for the per-stream record read-modify-write
//   (read cycle, update-and-write cycle) before it takes another item; failed
//   headers do not. A two-entry queue holds headers while the back end is busy.
// Reset: synchronous active-low; all per-stream records read as zero via valid
//   bits cleared at once, so no clearing pass is needed. Registers return to
//   60000 and 2097152.
// Stall: while i_out_stall is high the result holds; the queue fills and then
//   o_in_stall rises.
module chunked_frame_reassembly_tracker
    import cfrt_pkg::*;
#(
    parameter int STREAMS    = StreamsDef,
    parameter int MAX_CHUNKS = MaxChunksDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [21:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_kind,
    input  logic [15:0] i_stream_id,
    input  logic [15:0] i_frame_width,
    input  logic [15:0] i_frame_height,
    input  logic [31:0] i_frame_sequence,
    input  logic [31:0] i_total_bytes,
    input  logic [15:0] i_part_index,
    input  logic [15:0] i_part_count,
    input  logic [31:0] i_part_bytes,
    input  logic [15:0] i_bytes_present,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_status,
    output logic [15:0] o_out_stream,
    output logic [15:0] o_out_width,
    output logic [15:0] o_out_height,
    output logic [31:0] o_out_sequence,
    output logic [31:0] o_frames_received,
    output logic [31:0] o_frames_dropped
);

    logic [15:0] r_max_chunk;
    logic [21:0] r_max_frame;
    t_job        front_job;
    t_job        q_job;
    logic        q_full;
    logic        q_valid;
    logic        q_pop;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_chunk <= MaxChunkBytesRst;
            r_max_frame <= MaxFrameBytesRst;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MAX_CHUNK: r_max_chunk <= i_cfg_data[15:0];
                CFG_MAX_FRAME: r_max_frame <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_in_stall = q_full;

    cfrt_front #(.STREAMS(STREAMS), .MAX_CHUNKS(MAX_CHUNKS)) u_front (
        .i_kind           (i_kind),
        .i_stream_id      (i_stream_id),
        .i_frame_width    (i_frame_width),
        .i_frame_height   (i_frame_height),
        .i_frame_sequence (i_frame_sequence),
        .i_total_bytes    (i_total_bytes),
        .i_part_index     (i_part_index),
        .i_part_count     (i_part_count),
        .i_part_bytes     (i_part_bytes),
        .i_bytes_present  (i_bytes_present),
        .i_max_chunk      (r_max_chunk),
        .i_max_frame      (r_max_frame),
        .o_job            (front_job)
    );

    cfrt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_in_valid && !q_full),
        .i_job   (front_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_job   (q_job)
    );

    cfrt_back #(.STREAMS(STREAMS), .MAX_CHUNKS(MAX_CHUNKS)) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_q_valid         (q_valid),
        .i_q_job           (q_job),
        .o_q_pop           (q_pop),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_status          (o_status),
        .o_out_stream      (o_out_stream),
        .o_out_width       (o_out_width),
        .o_out_height      (o_out_height),
        .o_out_sequence    (o_out_sequence),
        .o_frames_received (o_frames_received),
        .o_frames_dropped  (o_frames_dropped)
    );

endmodule

[rtl/cfrt_checker.sv]
// port-level checker of the tracker and its bind
`include "chunked_frame_reassembly_tracker_macros.svh"

module cfrt_checker
    import cfrt_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [2:0]  o_status,
    input logic [15:0] o_out_stream,
    input logic [15:0] o_out_width,
    input logic [15:0] o_out_height,
    input logic [31:0] o_out_sequence,
    input logic [31:0] o_frames_received,
    input logic [31:0] o_frames_dropped
);

    // a stalled result item stays offered
    `CFRT_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid)

    // malformed items carry no stream and no counts
    `CFRT_ASSERT_NOW(a_malformed_zero, o_out_valid && o_status == ST_MALFORMED,
        o_out_stream == 16'd0 && o_frames_received == 32'd0 && o_frames_dropped == 32'd0)

    // frame fields appear only on completion
    `CFRT_ASSERT_NOW(a_frame_fields, o_out_valid && o_status != ST_COMPLETE,
        o_out_width == 16'd0 && o_out_height == 16'd0 && o_out_sequence == 32'd0)

    // a completed frame has been counted
    `CFRT_ASSERT_NOW(a_complete_count, o_out_valid && o_status == ST_COMPLETE,
        o_frames_received != 32'd0)

    // no result right after reset
    `CFRT_ASSERT_NEXT_ALWAYS(a_reset_idle, !i_rst_n, !o_out_valid && !o_in_stall)

endmodule

bind chunked_frame_reassembly_tracker cfrt_checker u_cfrt_checker (.*);

[sim/tb_top.sv]
// self-checking testbench of the chunked frame reassembly tracker
module tb_top;
    import cfrt_pkg::*;

    localparam int NSTREAMS   = 16;
    localparam int NCHUNKS    = 64;
    localparam int RAND_ITEMS = 400;
    localparam int IDLE_LIMIT = 5000;

    typedef struct {
        logic [1:0]  kind;
        logic [15:0] sid;
        logic [15:0] w;
        logic [15:0] h;
        logic [31:0] seq;
        logic [31:0] total;
        logic [15:0] idx;
        logic [15:0] cnt;
        logic [31:0] size;
        logic [15:0] present;
    } t_hdr;

    typedef struct {
        t_status     status;
        logic [15:0] stream;
        logic [15:0] w;
        logic [15:0] h;
        logic [31:0] seq;
        logic [31:0] rcv;
        logic [31:0] drop;
    } t_res;

    // frame tracking model with expected result queue
    class frame_scoreboard;
        logic [15:0] lim_chunk;
        logic [21:0] lim_frame;
        logic [31:0] last_seq [NSTREAMS];
        logic [31:0] rcv_cnt  [NSTREAMS];
        logic [31:0] drop_cnt [NSTREAMS];
        logic [31:0] pseq     [NSTREAMS];
        logic [31:0] ptot     [NSTREAMS];
        logic [15:0] pparts   [NSTREAMS];
        logic [31:0] pgeom    [NSTREAMS];
        logic [63:0] seen_map [NSTREAMS];
        logic [6:0]  seen_cnt [NSTREAMS];
        logic [21:0] bsum     [NSTREAMS];
        logic [15:0] sizes    [NSTREAMS*NCHUNKS];
        t_res        pending_results[$];
        int          mismatches;

        function new();
            lim_chunk = MaxChunkBytesRst;
            lim_frame = MaxFrameBytesRst;
            mismatches = 0;
            for (int s = 0; s < NSTREAMS; s++) begin
                last_seq[s] = 0; rcv_cnt[s] = 0; drop_cnt[s] = 0;
                drop_pending(s);
            end
        endfunction

        function void drop_pending(int s);
            pseq[s] = 0; ptot[s] = 0; pparts[s] = 0; pgeom[s] = 0;
            seen_map[s] = 0; seen_cnt[s] = 0; bsum[s] = 0;
        endfunction

        function void finish_frame(int s, logic [31:0] seq);
            if (last_seq[s] != 0 && seq > last_seq[s] + 32'd1)
                drop_cnt[s] = drop_cnt[s] + (seq - last_seq[s] - 32'd1);
            last_seq[s] = seq;
            rcv_cnt[s] = rcv_cnt[s] + 32'd1;
            drop_pending(s);
        endfunction

        function void set_reg(logic idx, logic [21:0] val);
            if (idx == CFG_MAX_CHUNK) lim_chunk = val[15:0];
            else lim_frame = val;
        endfunction

        // work out the result of one accepted header
        function void note_header(t_hdr x);
            t_res r;
            logic [31:0] geom;
            bit counts;
            int s;
            int slot;
            r = '{ST_MALFORMED, 0, 0, 0, 0, 0, 0};
            geom = 0;
            counts = 0;
            s = x.sid;
            if (x.kind != KIND_SINGLE && x.kind != KIND_CHUNK) begin
                pending_results.push_back(r);
                return;
            end
            r.stream = x.sid;
            if (x.kind == KIND_SINGLE) begin
                if (x.size == 0 || x.size > lim_chunk) r.status = ST_BAD_SIZE;
                else if (x.present < x.size) r.status = ST_TRUNCATED;
                else if (x.sid >= NSTREAMS) r.status = ST_UNKNOWN;
                else begin
                    finish_frame(s, x.seq);
                    geom = {x.w, x.h};
                    r.status = ST_COMPLETE;
                    counts = 1;
                end
            end else begin
                if (x.total == 0 || x.total > lim_frame || x.cnt == 0 || x.cnt > NCHUNKS
                    || x.idx >= x.cnt || x.size == 0 || x.size > lim_chunk)
                    r.status = ST_BAD_META;
                else if (x.present < x.size) r.status = ST_TRUNCATED;
                else if (x.sid >= NSTREAMS) r.status = ST_UNKNOWN;
                else begin
                    slot = s * NCHUNKS + x.idx;
                    if (pseq[s] != x.seq || ptot[s] != x.total || pparts[s] != x.cnt) begin
                        drop_pending(s);
                        pseq[s] = x.seq; ptot[s] = x.total; pparts[s] = x.cnt;
                        pgeom[s] = {x.w, x.h};
                    end
                    if (seen_map[s][x.idx]) bsum[s] = bsum[s] - sizes[slot][15:0];
                    else begin
                        seen_map[s][x.idx] = 1'b1;
                        seen_cnt[s] = seen_cnt[s] + 7'd1;
                    end
                    sizes[slot] = x.size[15:0];
                    bsum[s] = bsum[s] + x.size[21:0];
                    counts = 1;
                    if (seen_cnt[s] < pparts[s]) r.status = ST_STORED;
                    else if (bsum[s] != ptot[s]) begin
                        drop_pending(s);
                        r.status = ST_INCOMPLETE;
                    end else begin
                        geom = pgeom[s];
                        finish_frame(s, x.seq);
                        r.status = ST_COMPLETE;
                    end
                end
            end
            if (r.status == ST_COMPLETE) begin
                r.w = geom[31:16]; r.h = geom[15:0]; r.seq = x.seq;
            end
            if (counts) begin
                r.rcv = rcv_cnt[s]; r.drop = drop_cnt[s];
            end
            pending_results.push_back(r);
        endfunction

        function void check_result(t_res got);
            t_res e;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result status %0d", got.status);
                return;
            end
            e = pending_results.pop_front();
            if (got.status !== e.status || got.stream !== e.stream || got.w !== e.w
                || got.h !== e.h || got.seq !== e.seq || got.rcv !== e.rcv
                || got.drop !== e.drop) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch exp st=%0d s=%0d w=%0d h=%0d q=%0d r=%0d d=%0d got st=%0d s=%0d w=%0d h=%0d q=%0d r=%0d d=%0d",
                        e.status, e.stream, e.w, e.h, e.seq, e.rcv, e.drop, got.status,
                        got.stream, got.w, got.h, got.seq, got.rcv, got.drop);
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_idx;
    logic [21:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [1:0]  i_kind;
    logic [15:0] i_stream_id;
    logic [15:0] i_frame_width;
    logic [15:0] i_frame_height;
    logic [31:0] i_frame_sequence;
    logic [31:0] i_total_bytes;
    logic [15:0] i_part_index;
    logic [15:0] i_part_count;
    logic [31:0] i_part_bytes;
    logic [15:0] i_bytes_present;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [2:0]  o_status;
    logic [15:0] o_out_stream;
    logic [15:0] o_out_width;
    logic [15:0] o_out_height;
    logic [31:0] o_out_sequence;
    logic [31:0] o_frames_received;
    logic [31:0] o_frames_dropped;

    frame_scoreboard sb;
    bit  calm;
    bit  hold_rx;
    int  idle_cycles;

    chunked_frame_reassembly_tracker DUT (.*);

    // clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // accepted results go to the scoreboard
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_result('{t_status'(o_status), o_out_stream, o_out_width,
                o_out_height, o_out_sequence, o_frames_received, o_frames_dropped});
    end

    // receiver stall pattern
    always @(posedge i_clk) begin
        if (hold_rx) i_out_stall <= 1'b1;
        else if (calm) i_out_stall <= 1'b0;
        else i_out_stall <= ($urandom_range(99) < 33);
    end

    // watchdog on cycles with no handshake
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || !i_rst_n)
            idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // valid drops only in idle cycles, so back-to-back items keep it high
    task automatic send_header(t_hdr x);
        if (!calm) begin
            while ($urandom_range(99) < 33) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_in_valid       <= 1'b1;
        i_kind           <= x.kind;
        i_stream_id      <= x.sid;
        i_frame_width    <= x.w;
        i_frame_height   <= x.h;
        i_frame_sequence <= x.seq;
        i_total_bytes    <= x.total;
        i_part_index     <= x.idx;
        i_part_count     <= x.cnt;
        i_part_bytes     <= x.size;
        i_bytes_present  <= x.present;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_header(x);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [21:0] val);
        wait_drained();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_reg(idx, val);
    endtask

    function automatic t_hdr noise_header();
        t_hdr x;
        x.kind = $urandom_range(3);
        x.sid = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(NSTREAMS-1));
        x.w = $urandom; x.h = $urandom; x.seq = $urandom; x.total = $urandom;
        x.idx = $urandom; x.cnt = $urandom; x.size = $urandom; x.present = $urandom;
        if ($urandom_range(1)) begin
            x.idx = $urandom_range(70); x.cnt = $urandom_range(70);
            x.size = $urandom_range(70000); x.total = $urandom_range(4200000);
        end
        return x;
    endfunction

    // one chunked frame of random content, shuffled, sometimes damaged
    task automatic send_frame(int s, logic [31:0] seq);
        t_hdr x;
        int n;
        int sum;
        int order[$];
        logic [15:0] psz [64];
        n = ($urandom_range(9) == 0) ? $urandom_range(1, NCHUNKS) : $urandom_range(1, 5);
        sum = 0;
        for (int i = 0; i < n; i++) begin
            psz[i] = $urandom_range(1, 1500);
            sum += psz[i];
            order.push_back(i);
        end
        order.shuffle();
        if ($urandom_range(5) == 0) order.push_back($urandom_range(n-1));
        x.kind = KIND_CHUNK; x.sid = s; x.w = $urandom; x.h = $urandom; x.seq = seq;
        x.total = sum; x.cnt = n;
        foreach (order[k]) begin
            x.idx = order[k];
            x.size = psz[order[k]];
            if ($urandom_range(15) == 0) x.size = $urandom_range(1, 1500);
            x.present = ($urandom_range(19) == 0) ? x.size - 1 : x.size + $urandom_range(40);
            send_header(x);
        end
    endtask

    initial begin
        t_hdr x;
        logic [31:0] seqs [NSTREAMS];
        int s;
        sb = new();
        calm = 0; hold_rx = 0; idle_cycles = 0;
        i_rst_n = 1'b0; i_cfg_we = 1'b0; i_cfg_idx = 1'b0; i_cfg_data = '0;
        i_in_valid = 1'b0; i_out_stall = 1'b0;
        i_kind = 0; i_stream_id = 0; i_frame_width = 0; i_frame_height = 0;
        i_frame_sequence = 0; i_total_bytes = 0; i_part_index = 0; i_part_count = 0;
        i_part_bytes = 0; i_bytes_present = 0;
        foreach (seqs[k]) seqs[k] = 1;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes and each check
        x = '{KIND_SINGLE, 3, 16'hFFFF, 0, 5, 0, 0, 0, 100, 100}; send_header(x);
        x.seq = 9; send_header(x);                  // sequence gap
        x.seq = 32'hFFFF_FFFF; x.w = 0; x.h = 16'hFFFF; send_header(x);
        x.size = 0; send_header(x);                 // zero size
        x.size = 60001; x.present = 16'hFFFF; send_header(x);
        x.size = 60000; send_header(x);
        x.size = 32'hFFFF_FFFF; send_header(x);
        x.size = 200; x.present = 199; send_header(x);  // truncated
        x.present = 200; x.sid = 16; send_header(x);    // unknown stream
        x.sid = 16'hFFFF; send_header(x);
        x.kind = 2; send_header(x);
        x.kind = 3; send_header(x);
        x = '{KIND_CHUNK, 5, 640, 480, 7, 300, 0, 2, 100, 100}; send_header(x);
        x.idx = 0; x.size = 150; x.present = 150; send_header(x);  // replaced chunk
        x.idx = 1; send_header(x);                  // completes 150+150
        x = '{KIND_CHUNK, 5, 1, 2, 8, 300, 0, 2, 100, 100}; send_header(x);
        x.idx = 1; send_header(x);                  // sum mismatch
        x.idx = 2; send_header(x);                  // index not below count
        x.idx = 0; x.cnt = 0; send_header(x);
        x.cnt = 65; send_header(x);
        x.cnt = 64; x.idx = 63; x.total = 0; send_header(x);
        x.total = 2097153; send_header(x);
        x.total = 32'hFFFF_FFFF; send_header(x);
        x.total = 2097152; x.seq = 20; send_header(x);  // restart
        x.seq = 21; x.cnt = 1; x.idx = 0; x.total = 100; send_header(x);

        // register extremes
        write_reg(CFG_MAX_CHUNK, 16'hFFFF);
        write_reg(CFG_MAX_FRAME, 22'h3FFFFF);
        x = '{KIND_SINGLE, 2, 1, 1, 30, 0, 0, 0, 65535, 65535}; send_header(x);
        x = '{KIND_CHUNK, 2, 1, 1, 31, 4194303, 0, 64, 65535, 65535}; send_header(x);
        write_reg(CFG_MAX_CHUNK, 1);
        write_reg(CFG_MAX_FRAME, 1);
        x = '{KIND_SINGLE, 2, 1, 1, 40, 0, 0, 0, 1, 1}; send_header(x);
        x.size = 2; x.present = 2; send_header(x);
        x = '{KIND_CHUNK, 2, 1, 1, 41, 1, 0, 1, 1, 1}; send_header(x);
        x.total = 2; send_header(x);
        write_reg(CFG_MAX_CHUNK, 1500);
        write_reg(CFG_MAX_FRAME, 90000);

        // receiver holds off while sender keeps offering
        fork
            begin
                hold_rx = 1;
                repeat (200) @(posedge i_clk);
                hold_rx = 0;
            end
            for (int k = 0; k < 12; k++) send_header(noise_header());
        join

        // random: mostly well-formed frames, some noise
        for (int phase = 0; phase < 4; phase++) begin
            calm = (phase == 2);
            for (int k = 0; k < RAND_ITEMS / 22; k++) begin
                s = $urandom_range(NSTREAMS-1);
                if ($urandom_range(4) == 0) send_header(noise_header());
                else begin
                    seqs[s] = seqs[s] + $urandom_range(1, 3);
                    send_frame(s, seqs[s]);
                end
            end
            if (phase == 1) begin
                write_reg(CFG_MAX_CHUNK, MaxChunkBytesRst);
                write_reg(CFG_MAX_FRAME, MaxFrameBytesRst);
            end
        end
        calm = 1;

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending_results.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
